@@ hw/rtl/qvr_pkg.sv @@
// qvr_pkg: shared widths, payload types and rounding constants for the quaternion rotator
`default_nettype none

package qvr_pkg;

    localparam int QUAT_W = 16;   // Q2.14
    localparam int VEC_W  = 32;   // Q16.16

    // fraction bits dropped at the end: Q2.14 * Q2.14 * Q16.16 -> Q16.16
    localparam int FRAC_DROP = 28;

    // exact sum of the three terms fits well inside this many bits
    localparam int ACC_W = 67;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_DROP - 1);

    localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
    localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

    typedef enum logic
    {
        CMD_BODY_TO_WORLD = 1'b0,
        CMD_WORLD_TO_BODY = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                      cmd;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [VEC_W-1:0]   vec_x;
        logic signed [VEC_W-1:0]   vec_y;
        logic signed [VEC_W-1:0]   vec_z;
    } in_item_t;

    typedef struct packed
    {
        logic signed [VEC_W-1:0]   out_x;
        logic signed [VEC_W-1:0]   out_y;
        logic signed [VEC_W-1:0]   out_z;
        logic                      saturated;
    } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/qvr_in_if.sv @@
// qvr_in_if: valid/ready channel carrying one quaternion and vector per beat
`default_nettype none

interface qvr_in_if;

    logic               valid;
    logic               ready;
    qvr_pkg::in_item_t  data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

@@ hw/rtl/qvr_out_if.sv @@
// qvr_out_if: valid/ready channel carrying one rotated vector per beat
`default_nettype none

interface qvr_out_if;

    logic                valid;
    logic                ready;
    qvr_pkg::out_item_t  data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

@@ hw/rtl/quaternion_vector_rotation.sv @@
// quaternion_vector_rotation: five-stage pipelined sandwich-product vector rotator
//
// Rotates one Q16.16 3-vector by a Q2.14 quaternion per beat, cmd 0 giving q*v*conj(q) and
// cmd 1 giving conj(q)*v*q, using (w*w - u.u) v + 2 (u.v) u +/- 2 w (u x v) with no
// intermediate rounding, then one round to nearest (ties up) and saturation to 32 bits;
// saturated is set when any component clipped. The quaternion is not normalized, so the
// result scales with |q|^2. From input beat to output beat an item passes through the products
// of the inputs, the coefficient/dot/cross sums, the second multiplier bank, the three-term
// sum with rounding, and the saturating output register. A new beat is taken every cycle
// unless the output stalls; each stage holds its own valid bit, so bubbles close up and the
// input keeps accepting while a finished result waits at the output until the pipeline is full.
`default_nettype none

module quaternion_vector_rotation
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    qvr_in_if.sink      vec_in,
    qvr_out_if.source   vec_out
);

    localparam int QW     = qvr_pkg::QUAT_W;
    localparam int VW     = qvr_pkg::VEC_W;
    localparam int SQ_W   = 2 * QW;          // w*w and friends
    localparam int PV_W   = QW + VW;         // quaternion times vector component
    localparam int COEF_W = SQ_W + 1;
    localparam int CRS_W  = PV_W + 1;
    localparam int DOT_W  = PV_W + 2;
    localparam int WS_W   = QW + 2;
    localparam int ACC_W  = qvr_pkg::ACC_W;
    localparam int FD     = qvr_pkg::FRAC_DROP;
    localparam int NSTG   = 5;

    // stage 1: first multiplier bank
    typedef struct packed
    {
        logic signed [SQ_W-1:0]  ww;
        logic signed [SQ_W-1:0]  xx;
        logic signed [SQ_W-1:0]  yy;
        logic signed [SQ_W-1:0]  zz;
        logic signed [PV_W-1:0]  x_vx;
        logic signed [PV_W-1:0]  y_vy;
        logic signed [PV_W-1:0]  z_vz;
        logic signed [PV_W-1:0]  y_vz;
        logic signed [PV_W-1:0]  z_vy;
        logic signed [PV_W-1:0]  z_vx;
        logic signed [PV_W-1:0]  x_vz;
        logic signed [PV_W-1:0]  x_vy;
        logic signed [PV_W-1:0]  y_vx;
        logic signed [WS_W-1:0]  ws;
        logic signed [QW-1:0]    ux;
        logic signed [QW-1:0]    uy;
        logic signed [QW-1:0]    uz;
        logic signed [VW-1:0]    vx;
        logic signed [VW-1:0]    vy;
        logic signed [VW-1:0]    vz;
    } s1_t;

    // stage 2: coefficient, doubled dot product, cross product
    typedef struct packed
    {
        logic signed [COEF_W-1:0] coef;
        logic signed [DOT_W-1:0]  dot2;
        logic signed [CRS_W-1:0]  cx;
        logic signed [CRS_W-1:0]  cy;
        logic signed [CRS_W-1:0]  cz;
        logic signed [WS_W-1:0]   ws;
        logic signed [QW-1:0]     ux;
        logic signed [QW-1:0]     uy;
        logic signed [QW-1:0]     uz;
        logic signed [VW-1:0]     vx;
        logic signed [VW-1:0]     vy;
        logic signed [VW-1:0]     vz;
    } s2_t;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] en;

    s1_t s1_reg;
    s1_t s1_next;
    s2_t s2_reg;
    s2_t s2_next;

    logic signed [COEF_W+VW-1:0] pa_reg   [3];
    logic signed [COEF_W+VW-1:0] pa_next  [3];
    logic signed [DOT_W+QW-1:0]  pb_reg   [3];
    logic signed [DOT_W+QW-1:0]  pb_next  [3];
    logic signed [WS_W+CRS_W-1:0] pc_reg  [3];
    logic signed [WS_W+CRS_W-1:0] pc_next [3];

    logic signed [ACC_W-1:0] acc_reg  [3];
    logic signed [ACC_W-1:0] acc_next [3];

    qvr_pkg::out_item_t out_reg;
    qvr_pkg::out_item_t out_next;

    logic signed [QW-1:0]    u_lane [3];
    logic signed [VW-1:0]    v_lane [3];
    logic signed [CRS_W-1:0] c_lane [3];
    logic signed [VW-1:0]    res    [3];
    logic [2:0]              clip;

    // ---------------------------------------------------------------- flow control
    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || vec_out.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? vec_in.valid : valid_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign vec_in.ready  = en[0];
    assign vec_out.valid = valid_reg[NSTG-1];
    assign vec_out.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ---------------------------------------------------------------- stage 1
    always_comb
    begin
        s1_next.ww   = SQ_W'(vec_in.data.quat_w) * SQ_W'(vec_in.data.quat_w);
        s1_next.xx   = SQ_W'(vec_in.data.quat_x) * SQ_W'(vec_in.data.quat_x);
        s1_next.yy   = SQ_W'(vec_in.data.quat_y) * SQ_W'(vec_in.data.quat_y);
        s1_next.zz   = SQ_W'(vec_in.data.quat_z) * SQ_W'(vec_in.data.quat_z);
        s1_next.x_vx = PV_W'(vec_in.data.quat_x) * PV_W'(vec_in.data.vec_x);
        s1_next.y_vy = PV_W'(vec_in.data.quat_y) * PV_W'(vec_in.data.vec_y);
        s1_next.z_vz = PV_W'(vec_in.data.quat_z) * PV_W'(vec_in.data.vec_z);
        s1_next.y_vz = PV_W'(vec_in.data.quat_y) * PV_W'(vec_in.data.vec_z);
        s1_next.z_vy = PV_W'(vec_in.data.quat_z) * PV_W'(vec_in.data.vec_y);
        s1_next.z_vx = PV_W'(vec_in.data.quat_z) * PV_W'(vec_in.data.vec_x);
        s1_next.x_vz = PV_W'(vec_in.data.quat_x) * PV_W'(vec_in.data.vec_z);
        s1_next.x_vy = PV_W'(vec_in.data.quat_x) * PV_W'(vec_in.data.vec_y);
        s1_next.y_vx = PV_W'(vec_in.data.quat_y) * PV_W'(vec_in.data.vec_x);
        // signed 2w, negated for the world to body direction
        if (vec_in.data.cmd == qvr_pkg::CMD_WORLD_TO_BODY)
        begin
            s1_next.ws = -(WS_W'(vec_in.data.quat_w) <<< 1);
        end
        else
        begin
            s1_next.ws = WS_W'(vec_in.data.quat_w) <<< 1;
        end
        s1_next.ux = vec_in.data.quat_x;
        s1_next.uy = vec_in.data.quat_y;
        s1_next.uz = vec_in.data.quat_z;
        s1_next.vx = vec_in.data.vec_x;
        s1_next.vy = vec_in.data.vec_y;
        s1_next.vz = vec_in.data.vec_z;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        s2_next.coef = COEF_W'(s1_reg.ww) - COEF_W'(s1_reg.xx)
                     - COEF_W'(s1_reg.yy) - COEF_W'(s1_reg.zz);
        s2_next.dot2 = (DOT_W'(s1_reg.x_vx) + DOT_W'(s1_reg.y_vy) + DOT_W'(s1_reg.z_vz)) <<< 1;
        s2_next.cx   = CRS_W'(s1_reg.y_vz) - CRS_W'(s1_reg.z_vy);
        s2_next.cy   = CRS_W'(s1_reg.z_vx) - CRS_W'(s1_reg.x_vz);
        s2_next.cz   = CRS_W'(s1_reg.x_vy) - CRS_W'(s1_reg.y_vx);
        s2_next.ws   = s1_reg.ws;
        s2_next.ux   = s1_reg.ux;
        s2_next.uy   = s1_reg.uy;
        s2_next.uz   = s1_reg.uz;
        s2_next.vx   = s1_reg.vx;
        s2_next.vy   = s1_reg.vy;
        s2_next.vz   = s1_reg.vz;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        u_lane[0] = s2_reg.ux;
        u_lane[1] = s2_reg.uy;
        u_lane[2] = s2_reg.uz;
        v_lane[0] = s2_reg.vx;
        v_lane[1] = s2_reg.vy;
        v_lane[2] = s2_reg.vz;
        c_lane[0] = s2_reg.cx;
        c_lane[1] = s2_reg.cy;
        c_lane[2] = s2_reg.cz;
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = (COEF_W + VW)'(s2_reg.coef) * (COEF_W + VW)'(v_lane[i]);
            pb_next[i] = (DOT_W + QW)'(s2_reg.dot2) * (DOT_W + QW)'(u_lane[i]);
            pc_next[i] = (WS_W + CRS_W)'(s2_reg.ws) * (WS_W + CRS_W)'(c_lane[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
    end

    // ---------------------------------------------------------------- stage 4
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = ACC_W'(pa_reg[i]) + ACC_W'(pb_reg[i]) + ACC_W'(pc_reg[i])
                        + qvr_pkg::ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            acc_reg <= acc_next;
        end
    end

    // ---------------------------------------------------------------- stage 5
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // in range when every bit above the result's sign bit matches it
            if ((&acc_reg[i][ACC_W-1:FD+VW-1]) || !(|acc_reg[i][ACC_W-1:FD+VW-1]))
            begin
                res[i]  = acc_reg[i][FD+VW-1:FD];
                clip[i] = 1'b0;
            end
            else
            begin
                res[i]  = acc_reg[i][ACC_W-1] ? qvr_pkg::VEC_MIN : qvr_pkg::VEC_MAX;
                clip[i] = 1'b1;
            end
        end
        out_next.out_x     = res[0];
        out_next.out_y     = res[1];
        out_next.out_z     = res[2];
        out_next.saturated = |clip;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            out_reg <= out_next;
        end
    end

    // ---------------------------------------------------------------- checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NSTG-1] |-> vec_in.ready)
        else $error("input stalled while output register is empty");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_out.valid && vec_out.data.saturated) |->
            (vec_out.data.out_x == qvr_pkg::VEC_MAX || vec_out.data.out_x == qvr_pkg::VEC_MIN
          || vec_out.data.out_y == qvr_pkg::VEC_MAX || vec_out.data.out_y == qvr_pkg::VEC_MIN
          || vec_out.data.out_z == qvr_pkg::VEC_MAX || vec_out.data.out_z == qvr_pkg::VEC_MIN))
        else $error("saturation flag without a clipped component");

    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && !en[2]) |=> valid_reg[2])
        else $error("stalled product stage dropped its item");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vec_out.valid) |-> $past(valid_reg[NSTG-2]))
        else $error("output beat appeared without an item in the sum stage");

endmodule

`default_nettype wire
